>>> rtl/swr_pkg.sv
// Shared types, codes and constants of the scope waveform rasterizer.
package swr_pkg;

  // Default frame geometry
  localparam int DEF_FRAME_WIDTH  = 320;
  localparam int DEF_FRAME_HEIGHT = 160;

  // Q2.14 scale: fraction bits
  localparam int FRAC_BITS = 14;

  // Signed pixel coordinate, wide enough for a saturated row and column minus one
  localparam int COORD_W = 17;
  typedef logic signed [COORD_W-1:0] coord_t;

  // Trace row as produced by the sample conversion
  typedef logic signed [15:0] row_t;
  localparam row_t ROW_MAX = 16'sh7FFF;
  localparam row_t ROW_MIN = 16'sh8000;

  // 3-bit RGB color; black and white are replaced rather than blended
  typedef logic [2:0] color_t;
  localparam color_t COLOR_BLACK = 3'h0;
  localparam color_t COLOR_WHITE = 3'h7;

  // Input item commands
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLOT  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OFFSET = 2'd0,
    REG_SCALE  = 2'd1
  } reg_e;

  // Frame store operations
  typedef enum logic [1:0] {
    PIX_READ = 2'd0,
    PIX_PLOT = 2'd1,
    PIX_ZERO = 2'd2
  } pix_op_e;

  // Pixel request from the sequencer to the frame store
  typedef struct packed {
    logic    valid;
    pix_op_e op;
    coord_t  x;
    coord_t  y;
    color_t  color;
  } pix_req_t;

  // Read response from the frame store
  typedef struct packed {
    logic   valid;
    color_t color;
  } pix_rsp_t;

endpackage

>>> rtl/swr_row.sv
// Sample to row conversion: offset, Q2.14 scale, saturation and rounding.
module swr_row #(
  parameter int FRAME_HEIGHT = swr_pkg::DEF_FRAME_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [11:0]         sample,
  input  logic signed [13:0]  offset,
  input  logic [15:0]         scale,
  output logic                done,
  output swr_pkg::row_t       row
);
  import swr_pkg::*;

  localparam logic signed [32:0] TOP_Q  = 33'((FRAME_HEIGHT - 1) << FRAC_BITS);
  localparam logic signed [32:0] SAT_HI = 33'sd32767 <<< FRAC_BITS;
  localparam logic signed [32:0] SAT_LO = -(33'sd32768 <<< FRAC_BITS);
  localparam logic signed [32:0] HALF_Q = 33'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [32:0] BIAS_Q = (33'sd1 <<< FRAC_BITS) - 33'sd1;

  logic [3:0]         stg;
  logic signed [14:0] diff;
  logic signed [31:0] prod;
  logic signed [32:0] f_q;
  logic signed [32:0] g_q;
  logic               sat_hi_q;
  logic               sat_lo_q;
  logic signed [32:0] trunc;

  // Truncate toward zero: bias negative values before the shift
  assign trunc = g_q[32] ? (g_q + BIAS_Q) : g_q;

  // Advance the stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      stg  <= '0;
      done <= 1'b0;
    end else begin
      stg  <= {stg[2:0], start};
      done <= stg[3];
    end
  end

  // Datapath: difference, product, frame offset, round, saturate
  always_ff @(posedge clk) begin
    diff     <= $signed({3'b000, sample}) - $signed({offset[13], offset});
    prod     <= diff * $signed({1'b0, scale});
    f_q      <= TOP_Q - $signed({prod[31], prod});
    g_q      <= f_q + HALF_Q;
    sat_hi_q <= f_q > SAT_HI;
    sat_lo_q <= f_q < SAT_LO;
    if (stg[3]) begin
      if (sat_hi_q) begin
        row <= ROW_MAX;
      end else if (sat_lo_q) begin
        row <= ROW_MIN;
      end else begin
        row <= trunc[FRAC_BITS+15:FRAC_BITS];
      end
    end
  end

endmodule

>>> rtl/swr_frame.sv
// Frame store with a two-stage read-modify-write pixel unit.
module swr_frame #(
  parameter int FRAME_WIDTH  = swr_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = swr_pkg::DEF_FRAME_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  swr_pkg::pix_req_t req,
  output swr_pkg::pix_rsp_t rsp
);
  import swr_pkg::*;

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  color_t          mem [DEPTH];
  logic            in_frame;
  logic [AW-1:0]   ax;
  logic [AW-1:0]   ay;
  logic [AW-1:0]   addr;

  logic            s1_valid;
  pix_op_e         s1_op;
  logic            s1_in;
  logic [AW-1:0]   s1_addr;
  color_t          s1_color;
  logic            fwd_q;
  color_t          fwd_data_q;
  color_t          rd_q;

  color_t          old;
  color_t          wdata;
  logic            wr_en;

  // Bounds check and linear address of the request
  assign in_frame = (req.x >= 0) && (req.x < coord_t'(FRAME_WIDTH)) &&
                    (req.y >= 0) && (req.y < coord_t'(FRAME_HEIGHT));
  assign ax   = AW'(req.x);
  assign ay   = AW'(req.y);
  assign addr = AW'(ay * AW'(FRAME_WIDTH)) + ax;

  // Blend: a zero op writes black; black and white are replaced, other colors are ORed in
  always_comb begin
    old = fwd_q ? fwd_data_q : rd_q;
    if (s1_op == PIX_ZERO) begin
      wdata = COLOR_BLACK;
    end else if (old == COLOR_BLACK || old == COLOR_WHITE) begin
      wdata = s1_color;
    end else begin
      wdata = s1_color | old;
    end
    wr_en = s1_valid && s1_in && (s1_op != PIX_READ);
  end

  // Return read data; outside the frame reads as black
  assign rsp.valid = s1_valid && (s1_op == PIX_READ);
  assign rsp.color = s1_in ? old : COLOR_BLACK;

  // Hold stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req.valid;
    end
  end

  // Capture request payload and forward a write to the same pixel
  always_ff @(posedge clk) begin
    if (req.valid) begin
      s1_op      <= req.op;
      s1_in      <= in_frame;
      s1_addr    <= addr;
      s1_color   <= req.color;
      fwd_q      <= wr_en && (s1_addr == addr);
      fwd_data_q <= wdata;
    end
  end

  // Frame memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= wdata;
    end
    if (req.valid && in_frame) begin
      rd_q <= mem[addr];
    end
  end

endmodule

>>> rtl/scope_waveform_rasterizer.sv
// Scope trace rasterizer: command sequencer, row conversion and frame store.
// Read pixel: the read is issued once the result register is free. Plot: the point,
// then one pixel per cycle for each visible row of the vertical gap fill (up to
// FRAME_HEIGHT), set by the single read-modify-write port of the frame store. Clear:
// one pixel per cycle over all FRAME_WIDTH*FRAME_HEIGHT pixels.
// Reset runs the same clearing pass over the frame store before the first item
// is accepted; configuration writes are taken at any time.
module scope_waveform_rasterizer #(
  parameter int FRAME_WIDTH  = swr_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = swr_pkg::DEF_FRAME_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // sample[11:0], column[20:12], row[28:21], trace_color[31:29]
  input  logic [2:0]  s_tuser,    // command[1:0], first_point[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // pixel_color[2:0], zero[7:3]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [swr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import swr_pkg::*;

  localparam int XW = $clog2(FRAME_WIDTH);
  localparam int YW = $clog2(FRAME_HEIGHT);
  localparam coord_t H_MAX = coord_t'(FRAME_HEIGHT - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROW,
    S_POINT,
    S_SETUP,
    S_FILL,
    S_READ,
    S_RWAIT
  } state_t;

  state_t             state;
  logic signed [13:0] offset_digits;
  logic [15:0]        pixel_scale;
  row_t               previous_row;

  logic [XW-1:0]      clr_x;
  logic [YW-1:0]      clr_y;
  logic [8:0]         col_q;
  logic [7:0]         rd_row_q;
  color_t             color_q;
  logic               first_q;

  row_t               last_q;
  logic               up_q;
  coord_t             mid_q;
  logic               fill_q;
  coord_t             lo_raw_q;
  coord_t             hi_raw_q;
  coord_t             walk_r;
  coord_t             hi_q;

  logic               out_valid;
  color_t             out_color;

  logic               accept;
  logic               row_start;
  logic               row_done;
  row_t               row_y;
  pix_req_t           pix_req;
  pix_rsp_t           pix_rsp;

  coord_t             col_c;
  coord_t             yc;
  coord_t             lc;
  logic               up;
  coord_t             gap_dist;
  coord_t             lo_c;
  coord_t             hi_c;
  coord_t             jc;
  logic               read_go;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign row_start = accept && (s_tuser[1:0] == CMD_PLOT);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {5'b00000, out_color};
  assign read_go   = !out_valid || m_tready;

  // Gap geometry from the new row and the previous one
  always_comb begin
    col_c    = coord_t'(col_q);
    yc       = coord_t'(row_y);
    lc       = coord_t'(previous_row);
    up       = yc > lc;
    gap_dist = up ? (yc - lc) : (lc - yc);
    lo_c     = (lo_raw_q < 0) ? '0 : lo_raw_q;
    hi_c     = (hi_raw_q > H_MAX) ? H_MAX : hi_raw_q;
    jc       = up_q ? (walk_r - coord_t'(last_q)) : (coord_t'(last_q) - walk_r);
  end

  // Drive the frame store from the current sequencer step
  always_comb begin
    pix_req.valid = 1'b0;
    pix_req.op    = PIX_READ;
    pix_req.x     = col_c;
    pix_req.y     = coord_t'(rd_row_q);
    pix_req.color = color_q;
    case (state)
      S_CLEAR: begin
        pix_req.valid = 1'b1;
        pix_req.op    = PIX_ZERO;
        pix_req.x     = coord_t'(clr_x);
        pix_req.y     = coord_t'(clr_y);
      end
      S_POINT: begin
        pix_req.valid = 1'b1;
        pix_req.op    = PIX_PLOT;
        pix_req.y     = yc;
      end
      S_FILL: begin
        pix_req.valid = 1'b1;
        pix_req.op    = PIX_PLOT;
        pix_req.x     = (jc < mid_q) ? (col_c - coord_t'(1)) : col_c;
        pix_req.y     = walk_r;
      end
      S_READ: begin
        pix_req.valid = read_go;
      end
      default: begin
        pix_req.valid = 1'b0;
      end
    endcase
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_digits <= '0;
      pixel_scale   <= 16'd528;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OFFSET: offset_digits <= cfg_data[13:0];
        REG_SCALE:  pixel_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: state, gap walk and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_x        <= '0;
      clr_y        <= '0;
      previous_row <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_x == XW'(FRAME_WIDTH - 1)) begin
            clr_x <= '0;
            if (clr_y == YW'(FRAME_HEIGHT - 1)) begin
              state <= S_IDLE;
            end else begin
              clr_y <= clr_y + YW'(1);
            end
          end else begin
            clr_x <= clr_x + XW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            col_q    <= s_tdata[20:12];
            rd_row_q <= s_tdata[28:21];
            color_q  <= s_tdata[31:29];
            first_q  <= s_tuser[2];
            case (s_tuser[1:0])
              CMD_CLEAR: begin
                clr_x <= '0;
                clr_y <= '0;
                state <= S_CLEAR;
              end
              CMD_PLOT: state <= S_ROW;
              CMD_READ: state <= S_READ;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_ROW: begin
          if (row_done) begin
            state <= S_POINT;
          end
        end
        S_POINT: begin
          previous_row <= row_y;
          last_q       <= previous_row;
          up_q         <= up;
          mid_q        <= gap_dist >>> 1;
          fill_q       <= !first_q && (gap_dist > coord_t'(1));
          lo_raw_q     <= up ? lc : (yc + coord_t'(1));
          hi_raw_q     <= up ? (yc - coord_t'(1)) : lc;
          state        <= S_SETUP;
        end
        S_SETUP: begin
          walk_r <= lo_c;
          hi_q   <= hi_c;
          state  <= (fill_q && (lo_c <= hi_c)) ? S_FILL : S_IDLE;
        end
        S_FILL: begin
          walk_r <= walk_r + coord_t'(1);
          if (walk_r == hi_q) begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          if (read_go) begin
            state <= S_RWAIT;
          end
        end
        S_RWAIT: begin
          if (pix_rsp.valid) begin
            out_valid <= 1'b1;
            out_color <= pix_rsp.color;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  swr_row #(
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_row (
    .clk    (clk),
    .rst    (rst),
    .start  (row_start),
    .sample (s_tdata[11:0]),
    .offset (offset_digits),
    .scale  (pixel_scale),
    .done   (row_done),
    .row    (row_y)
  );

  swr_frame #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_frame (
    .clk (clk),
    .rst (rst),
    .req (pix_req),
    .rsp (pix_rsp)
  );

endmodule

>>> rtl/swr_checker.sv
// Port-level checks of the rasterizer and their binding to the top level.
module swr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);
  import swr_pkg::*;

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset starts the clearing pass, so no item is taken right after it
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready during clearing pass");

  // Input is not ready right after any command is accepted
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    (s_tuser[1:0] == CMD_CLEAR || s_tuser[1:0] == CMD_PLOT || s_tuser[1:0] == CMD_READ)
    |=> !s_tready)
    else $error("input ready right after a command");

  // A result only appears at the end of a read, while input is held off
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without a read in progress");

endmodule

bind scope_waveform_rasterizer swr_checker u_swr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
